/* rtl/core/key_gesture_detector_core_defines.svh */
// assertion macros for the key gesture detector checks
`ifndef KEY_GESTURE_DETECTOR_CORE_DEFINES_SVH
`define KEY_GESTURE_DETECTOR_CORE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define KGD_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("key gesture check failed");

// consequent holds in the cycle after the antecedent
`define KGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key gesture check failed");

`endif

/* rtl/core/kgd_pkg.sv */
// shared constants and types of the key gesture detector
package kgd_pkg;

    localparam int NUM_KEYS       = 5;
    localparam int COUNT_BITS     = 12;
    localparam int REG_BITS       = 12;
    localparam int FIELD_BITS     = 5;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CMP_BITS       = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;

    localparam logic [REG_BITS-1:0] DOUBLE_WINDOW_RESET = REG_BITS'(20);
    localparam logic [REG_BITS-1:0] LONG_PRESS_RESET    = REG_BITS'(20);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX         = {COUNT_BITS{1'b1}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DOUBLE_WINDOW = 1'b0,
        REG_LONG_PRESS    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [REG_BITS-1:0] double_window;
        logic [REG_BITS-1:0] long_press;
    } cfg_t;

    typedef struct packed {
        logic press;
        logic release_edge;
        logic click;
        logic double_click;
        logic long_press;
        logic double_long;
    } lane_ev_t;

endpackage

/* rtl/core/kgd_if.sv */
// handshake channel interfaces of the key gesture detector
interface kgd_in_if;
    import kgd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

interface kgd_out_if;
    import kgd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] press_edges;
    logic [FIELD_BITS-1:0] release_edges;
    logic [FIELD_BITS-1:0] click_mask;
    logic [FIELD_BITS-1:0] double_click_mask;
    logic [FIELD_BITS-1:0] long_press_mask;
    logic [FIELD_BITS-1:0] double_long_mask;

    modport source (output valid, output press_edges, output release_edges,
                    output click_mask, output double_click_mask,
                    output long_press_mask, output double_long_mask, input ready);
    modport sink   (input valid, input press_edges, input release_edges,
                    input click_mask, input double_click_mask,
                    input long_press_mask, input double_long_mask, output ready);
endinterface

interface kgd_cfg_if;
    import kgd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [REG_BITS-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/key_gesture_detector_core.sv */
// key gesture detector: one scan tick in, one beat of event masks out
// a tick's result beat is offered in the cycle after the tick is accepted
// throughput: one tick per cycle while the sink keeps up; each key has its own lane, so no unit is shared
// the input stalls only while a finished result beat waits and the sink is not ready
// reset: all keys released, counters and flags zero, both time registers 20,
// no result beat pending; no clearing pass is needed
module key_gesture_detector_core
    import kgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    kgd_in_if.sink    key_in,
    kgd_out_if.source evt_out,
    kgd_cfg_if.sink   cfg
);

    // configuration registers; the user must write them only while idle, the block does not enforce this
    logic [REG_BITS-1:0] window_reg, window_next;
    logic [REG_BITS-1:0] long_reg, long_next;
    cfg_t                cfg_cur;

    // a tick is taken whenever the output register is free or being drained
    logic                load_ok;
    logic                step;
    logic [NUM_KEYS-1:0] levels;
    lane_ev_t            lane_ev [NUM_KEYS];

    assign cfg.ready = 1'b1;

    // register write decode, one register per beat
    always_comb
    begin
        window_next = window_reg;
        long_next   = long_reg;
        if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_DOUBLE_WINDOW: window_next = cfg.data;
                REG_LONG_PRESS:    long_next   = cfg.data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= DOUBLE_WINDOW_RESET;
            long_reg   <= LONG_PRESS_RESET;
        end
        else
        begin
            window_reg <= window_next;
            long_reg   <= long_next;
        end
    end

    assign cfg_cur.double_window = window_reg;
    assign cfg_cur.long_press    = long_reg;

    assign key_in.ready = load_ok;
    assign step         = key_in.valid && load_ok;

    // keys past the field width have no pin and read as pressed
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        if (k < FIELD_BITS)
        begin : g_pin
            assign levels[k] = key_in.key_levels[k];
        end
        else
        begin : g_nopin
            assign levels[k] = 1'b0;
        end

        // one lane per key, all lanes step on the same tick
        kgd_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (step),
            .level (levels[k]),
            .cfg   (cfg_cur),
            .ev    (lane_ev[k])
        );
    end

    // gathers the lane events into the six masks of one result beat
    kgd_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .lane_ev (lane_ev),
        .load_ok (load_ok),
        .evt_out (evt_out)
    );

endmodule

/* rtl/core/kgd_lane.sv */
// per-key gesture state and event logic
module kgd_lane
    import kgd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  logic     level,
    input  cfg_t     cfg,
    output lane_ev_t ev
);

    logic                  last_level_reg, last_level_next;
    logic                  double_reg, double_next;
    logic                  long_rep_reg, long_rep_next;
    logic [COUNT_BITS-1:0] tsc_reg, tsc_next;
    logic [COUNT_BITS-1:0] tsp_reg, tsp_next;

    logic [COUNT_BITS-1:0] tsc_inc, tsp_inc;
    logic                  change, is_press, is_release, is_short, long_hit;

    always_comb
    begin
        tsc_inc    = (tsc_reg == COUNT_MAX) ? COUNT_MAX : tsc_reg + 1'b1;
        tsp_inc    = (tsp_reg == COUNT_MAX) ? COUNT_MAX : tsp_reg + 1'b1;
        change     = level != last_level_reg;
        is_press   = change && !level;
        is_release = change && level;
        is_short   = CMP_BITS'(tsc_inc) < CMP_BITS'(cfg.long_press);
        long_hit   = !change && !level && !long_rep_reg
                     && (CMP_BITS'(tsc_inc) >= CMP_BITS'(cfg.long_press));

        ev.press        = is_press;
        ev.release_edge = is_release;
        ev.click        = is_release && is_short && !double_reg;
        ev.double_click = is_release && is_short && double_reg;
        ev.long_press   = long_hit && !double_reg;
        ev.double_long  = long_hit && double_reg;

        last_level_next = level;
        tsc_next        = change ? '0 : tsc_inc;
        tsp_next        = is_press ? '0 : tsp_inc;
        long_rep_next   = change ? 1'b0 : (long_hit ? 1'b1 : long_rep_reg);
        if (is_press)
        begin
            double_next = CMP_BITS'(tsp_inc) < CMP_BITS'(cfg.double_window);
        end
        else if ((is_release && is_short) || long_hit)
        begin
            double_next = 1'b0;
        end
        else
        begin
            double_next = double_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b1;
            double_reg     <= 1'b0;
            long_rep_reg   <= 1'b0;
            tsc_reg        <= '0;
            tsp_reg        <= '0;
        end
        else if (step)
        begin
            last_level_reg <= last_level_next;
            double_reg     <= double_next;
            long_rep_reg   <= long_rep_next;
            tsc_reg        <= tsc_next;
            tsp_reg        <= tsp_next;
        end
    end

endmodule

/* rtl/core/kgd_merge.sv */
// merges lane events into result masks and holds the output beat
module kgd_merge
    import kgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  lane_ev_t  lane_ev [NUM_KEYS],
    output logic      load_ok,
    kgd_out_if.source evt_out
);

    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0] press_reg, release_reg, click_reg;
    logic [FIELD_BITS-1:0] dclick_reg, long_reg, dlong_reg;
    logic [FIELD_BITS-1:0] press_next, release_next, click_next;
    logic [FIELD_BITS-1:0] dclick_next, long_next, dlong_next;

    // keys beyond the field width are dropped, missing keys read as no event
    for (genvar f = 0; f < FIELD_BITS; f++)
    begin : g_bit
        if (f < NUM_KEYS)
        begin : g_key
            assign press_next[f]   = lane_ev[f].press;
            assign release_next[f] = lane_ev[f].release_edge;
            assign click_next[f]   = lane_ev[f].click;
            assign dclick_next[f]  = lane_ev[f].double_click;
            assign long_next[f]    = lane_ev[f].long_press;
            assign dlong_next[f]   = lane_ev[f].double_long;
        end
        else
        begin : g_none
            assign press_next[f]   = 1'b0;
            assign release_next[f] = 1'b0;
            assign click_next[f]   = 1'b0;
            assign dclick_next[f]  = 1'b0;
            assign long_next[f]    = 1'b0;
            assign dlong_next[f]   = 1'b0;
        end
    end

    assign load_ok        = !out_valid_reg || evt_out.ready;
    assign out_valid_next = step ? 1'b1 : (evt_out.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            press_reg   <= press_next;
            release_reg <= release_next;
            click_reg   <= click_next;
            dclick_reg  <= dclick_next;
            long_reg    <= long_next;
            dlong_reg   <= dlong_next;
        end
    end

    assign evt_out.valid             = out_valid_reg;
    assign evt_out.press_edges       = press_reg;
    assign evt_out.release_edges     = release_reg;
    assign evt_out.click_mask        = click_reg;
    assign evt_out.double_click_mask = dclick_reg;
    assign evt_out.long_press_mask   = long_reg;
    assign evt_out.double_long_mask  = dlong_reg;

endmodule

/* rtl/core/kgd_checker.sv */
// port-level checks of the key gesture detector and their bind
`include "key_gesture_detector_core_defines.svh"

module kgd_checker
    import kgd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [FIELD_BITS-1:0] press_edges,
    input logic [FIELD_BITS-1:0] release_edges,
    input logic [FIELD_BITS-1:0] click_mask,
    input logic [FIELD_BITS-1:0] double_click_mask,
    input logic [FIELD_BITS-1:0] long_press_mask,
    input logic [FIELD_BITS-1:0] double_long_mask
);

    // a key cannot both press and release in one tick
    `KGD_ASSERT_ALWAYS(a_edges_disjoint, !out_valid || ((press_edges & release_edges) == '0))

    // clicks only come with a release and are never both kinds
    `KGD_ASSERT_ALWAYS(a_click_on_release, !out_valid || ((((click_mask | double_click_mask) & ~release_edges) == '0) && ((click_mask & double_click_mask) == '0)))

    // long reports only on held ticks without an edge
    `KGD_ASSERT_ALWAYS(a_long_no_edge, !out_valid || (((long_press_mask | double_long_mask) & (press_edges | release_edges)) == '0))

    // every accepted tick yields a result beat on the next cycle
    `KGD_ASSERT_NEXT(a_tick_gives_beat, in_valid && in_ready, out_valid)

    // a stalled result beat stays offered
    `KGD_ASSERT_NEXT(a_beat_holds, out_valid && !out_ready, out_valid)

endmodule

bind key_gesture_detector_core kgd_checker u_kgd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (key_in.valid),
    .in_ready          (key_in.ready),
    .out_valid         (evt_out.valid),
    .out_ready         (evt_out.ready),
    .press_edges       (evt_out.press_edges),
    .release_edges     (evt_out.release_edges),
    .click_mask        (evt_out.click_mask),
    .double_click_mask (evt_out.double_click_mask),
    .long_press_mask   (evt_out.long_press_mask),
    .double_long_mask  (evt_out.double_long_mask)
);

/* dv/key_gesture_detector_core_tb.sv */
// testbench for key_gesture_detector_core: directed and random scan ticks checked against a gesture predictor
module key_gesture_detector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kgd_pkg::*;

    // run bounds: the slowest legal run has idle gaps and one long hold
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    // one result beat, field for field as on evt_out
    typedef struct packed {
        logic [FIELD_BITS-1:0] press_edges;
        logic [FIELD_BITS-1:0] release_edges;
        logic [FIELD_BITS-1:0] click_mask;
        logic [FIELD_BITS-1:0] double_click_mask;
        logic [FIELD_BITS-1:0] long_press_mask;
        logic [FIELD_BITS-1:0] double_long_mask;
    } gesture_masks_t;

    logic clk;
    logic rst_n;

    kgd_in_if  key_in_bus ();
    kgd_out_if evt_bus ();
    kgd_cfg_if cfg_bus ();

    key_gesture_detector_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_in  (key_in_bus.sink),
        .evt_out (evt_bus.source),
        .cfg     (cfg_bus.sink)
    );

    // scan ticks waiting to be offered, expected result beats in order
    logic [FIELD_BITS-1:0] scan_ticks [$];
    gesture_masks_t        pending_gestures [$];

    int  ticks_queued;
    int  ticks_accepted;
    int  mismatches;
    bit  tick_taken;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_request;
    int  hold_left;

    // predictor copy of the timer registers
    logic [REG_BITS-1:0] double_window;
    logic [REG_BITS-1:0] long_press;

    // predictor copy of the per-key state
    logic                  key_level   [NUM_KEYS];
    logic                  dbl_pending [NUM_KEYS];
    logic                  long_done   [NUM_KEYS];
    logic [COUNT_BITS-1:0] hold_ticks  [NUM_KEYS];
    logic [COUNT_BITS-1:0] press_age   [NUM_KEYS];

    // stimulus generator: level and remaining run length of each key
    logic [FIELD_BITS-1:0] gen_level;
    int                    gen_run [NUM_KEYS];

    // clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // advance every key by one scan tick and return the event masks it raises
    function automatic gesture_masks_t scan_tick(input logic [FIELD_BITS-1:0] levels);
        gesture_masks_t ev;
        logic           cur;
        ev = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            cur = levels[k];
            // both counters move first and stick at their maximum
            if (hold_ticks[k] != COUNT_MAX)
                hold_ticks[k] = hold_ticks[k] + 1'b1;
            if (press_age[k] != COUNT_MAX)
                press_age[k] = press_age[k] + 1'b1;
            if (cur != key_level[k])
            begin
                if (!cur)
                begin
                    // new press: double when the last press is still inside the window
                    ev.press_edges[k] = 1'b1;
                    dbl_pending[k]    = (press_age[k] < double_window);
                    press_age[k]      = '0;
                end
                else
                begin
                    ev.release_edges[k] = 1'b1;
                    // short hold ends in a click of either kind
                    if (hold_ticks[k] < long_press)
                    begin
                        if (dbl_pending[k])
                            ev.double_click_mask[k] = 1'b1;
                        else
                            ev.click_mask[k] = 1'b1;
                        dbl_pending[k] = 1'b0;
                    end
                end
                hold_ticks[k] = '0;
                key_level[k]  = cur;
                long_done[k]  = 1'b0;
            end
            else if (!cur && hold_ticks[k] >= long_press && !long_done[k])
            begin
                // long hold reported once per press
                if (dbl_pending[k])
                    ev.double_long_mask[k] = 1'b1;
                else
                    ev.long_press_mask[k] = 1'b1;
                dbl_pending[k] = 1'b0;
                long_done[k]   = 1'b1;
            end
        end
        return ev;
    endfunction

    // run length of the next level of a key, clustered around the timer thresholds
    function automatic int pick_run(input logic pressed, input int dw, input int lp);
        int base;
        int sel;
        base = pressed ? lp : dw;
        if (base < 1)
            base = 1;
        if (base > 48)
            base = 48;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom_range(1, base);
        if (sel < 8)
            return (base > 1) ? $urandom_range(base - 1, base + 1) : $urandom_range(1, 2);
        return $urandom_range(base + 1, 2 * base + 4);
    endfunction

    task automatic queue_tick(input logic [FIELD_BITS-1:0] levels);
        scan_ticks.push_back(levels);
        ticks_queued++;
    endtask

    // one beat on the register channel, only called while the block is idle
    task automatic write_reg(input cfg_index_t idx, input logic [REG_BITS-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // counters only move at rising edges, so reading them at the falling edge is race free
    task automatic wait_drained();
        do
            @(negedge clk);
        while (ticks_accepted != ticks_queued || pending_gestures.size() != 0);
        // settling margin before the next phase
        repeat (3) @(negedge clk);
    endtask

    // mostly well formed press / release runs, with single-tick glitches as noise
    task automatic run_random_phase(input logic [REG_BITS-1:0] dw, input logic [REG_BITS-1:0] lp,
                                    input int send_pct, input int recv_pct, input int n,
                                    input bit with_hold);
        logic [FIELD_BITS-1:0] lv;
        write_reg(REG_DOUBLE_WINDOW, dw);
        write_reg(REG_LONG_PRESS, lp);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (gen_run[k] == 0)
                begin
                    gen_level[k] = ~gen_level[k];
                    gen_run[k]   = pick_run(!gen_level[k], int'(dw), int'(lp));
                end
                gen_run[k]--;
            end
            lv = gen_level;
            if ($urandom_range(0, 11) == 0)
                lv = lv ^ FIELD_BITS'($urandom_range(1, 31));
            queue_tick(lv);
        end
        if (with_hold)
        begin
            // long receiver hold-off while the sender keeps offering ticks
            @(posedge clk);
            hold_request = 1'b1;
        end
        wait_drained();
    endtask

    // input driver: next tick or an idle cycle once the current beat is taken
    always @(negedge clk)
    begin
        if (rst_n && (!key_in_bus.valid || tick_taken))
        begin
            tick_taken = 1'b0;
            if (scan_ticks.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                key_in_bus.valid      <= 1'b1;
                key_in_bus.key_levels <= scan_ticks.pop_front();
            end
            else
            begin
                key_in_bus.valid <= 1'b0;
            end
        end
    end

    // result-side ready: random stalls, or one long counted hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            evt_bus.ready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            evt_bus.ready <= 1'b0;
        end
        else
        begin
            evt_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: register writes, accepted ticks and result beats at the rising edge
    always @(posedge clk)
    begin
        gesture_masks_t got;
        gesture_masks_t want;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_index_t'(cfg_bus.index))
                    REG_DOUBLE_WINDOW: double_window = cfg_bus.data;
                    REG_LONG_PRESS:    long_press    = cfg_bus.data;
                    default:           ;
                endcase
            end
            if (key_in_bus.valid && key_in_bus.ready)
            begin
                pending_gestures.push_back(scan_tick(key_in_bus.key_levels));
                ticks_accepted++;
                tick_taken = 1'b1;
            end
            if (evt_bus.valid && evt_bus.ready)
            begin
                got.press_edges       = evt_bus.press_edges;
                got.release_edges     = evt_bus.release_edges;
                got.click_mask        = evt_bus.click_mask;
                got.double_click_mask = evt_bus.double_click_mask;
                got.long_press_mask   = evt_bus.long_press_mask;
                got.double_long_mask  = evt_bus.double_long_mask;
                if (pending_gestures.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] result beat with no tick pending: %b", $realtime, got);
                end
                else
                begin
                    want = pending_gestures.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"[%0t] gesture mismatch (press release click dclick long",
                                      " dlong) expected %b %b %b %b %b %b got %b %b %b %b %b %b"},
                                     $realtime, want.press_edges, want.release_edges,
                                     want.click_mask, want.double_click_mask,
                                     want.long_press_mask, want.double_long_mask,
                                     got.press_edges, got.release_edges, got.click_mask,
                                     got.double_click_mask, got.long_press_mask,
                                     got.double_long_mask);
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n                 = 1'b0;
        key_in_bus.valid      = 1'b0;
        key_in_bus.key_levels = '1;
        evt_bus.ready         = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = REG_DOUBLE_WINDOW;
        cfg_bus.data          = '0;
        ticks_queued          = 0;
        ticks_accepted        = 0;
        mismatches            = 0;
        tick_taken            = 1'b0;
        send_idle_pct         = 34;
        recv_idle_pct         = 55;
        hold_request          = 1'b0;
        hold_left             = 0;

        // predictor mirrors the reset state: all released, counters and flags clear
        double_window = DOUBLE_WINDOW_RESET;
        long_press    = LONG_PRESS_RESET;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_level[k]   = 1'b1;
            dbl_pending[k] = 1'b0;
            long_done[k]   = 1'b0;
            hold_ticks[k]  = '0;
            press_age[k]   = '0;
            gen_run[k]     = $urandom_range(0, 5);
        end
        gen_level = '1;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed: short timers so every gesture fits in a few ticks
        write_reg(REG_DOUBLE_WINDOW, REG_BITS'(4));
        write_reg(REG_LONG_PRESS, REG_BITS'(3));
        // key 0 pressed right after reset counts as double, short release gives a double click
        queue_tick(5'b11110);
        queue_tick(5'b11110);
        queue_tick(5'b11111);
        // key 1 held to the long time, no repeat, late release gives no click
        queue_tick(5'b11101);
        queue_tick(5'b11101);
        queue_tick(5'b11101);
        queue_tick(5'b11101);
        queue_tick(5'b11101);
        queue_tick(5'b11111);
        // key 2: click, quick second press, hold gives a double long press
        queue_tick(5'b11011);
        queue_tick(5'b11111);
        queue_tick(5'b11011);
        queue_tick(5'b11011);
        queue_tick(5'b11011);
        queue_tick(5'b11011);
        queue_tick(5'b11111);
        // every key at once, both extremes of the level field
        queue_tick(5'b00000);
        queue_tick(5'b11111);
        queue_tick(5'b00000);
        queue_tick(5'b00000);
        queue_tick(5'b11111);
        queue_tick(5'b10101);
        queue_tick(5'b01010);
        queue_tick(5'b11111);
        wait_drained();

        // random phases, receiver idles more first, then the sender, then neither
        run_random_phase(REG_BITS'(20), REG_BITS'(20), 34, 55, 400, 1'b0);
        // zero timers: never double, never a click, long on the first held tick
        run_random_phase(REG_BITS'(0), REG_BITS'(0), 34, 55, 200, 1'b0);
        run_random_phase(REG_BITS'(1), REG_BITS'(1), 55, 34, 200, 1'b0);
        run_random_phase(REG_BITS'(6), REG_BITS'(3), 55, 34, 300, 1'b0);

        run_random_phase(REG_BITS'(40), REG_BITS'(12), 0, 0, 400, 1'b1);
        // widest window with zero long time
        run_random_phase(COUNT_MAX, REG_BITS'(0), 0, 0, 100, 1'b0);

        if (mismatches == 0 && pending_gestures.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
